// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or expression on every rising clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== design/bec_pkg.sv =====
// ----------------------------------------------------------------------------
// bec_pkg
// Types and constants of the biconnected edge component block.
// ----------------------------------------------------------------------------
package bec_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;

    localparam int V_W   = $clog2(MAX_VERTICES);          // vertex id
    localparam int VC_W  = V_W + 1;                       // vertex count / time
    localparam int E_W   = $clog2(MAX_EDGES);             // edge id
    localparam int EC_W  = E_W + 1;                       // edge count
    localparam int A_W   = E_W + 1;                       // adjacency address
    localparam int OFF_W = A_W + 1;                       // adjacency offset

    localparam logic [VC_W-1:0] TIME_INF = VC_W'(MAX_VERTICES + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic            operation;
        logic [V_W-1:0]  from_vertex;
        logic [V_W-1:0]  to_vertex;
        logic            last_edge;
        logic [E_W-1:0]  edge_index;
    } t_req;

    typedef struct packed {
        logic            is_count;
        logic [12:0]     component_count;
        logic [12:0]     edge_color;
        logic            overflow;
    } t_rsp;

    typedef struct packed {
        logic [V_W-1:0]   v;
        logic [V_W-1:0]   par;
        logic             par_vld;
        logic [OFF_W-1:0] pos;
        logic [OFF_W-1:0] lim;
        logic [VC_W-1:0]  low;
        logic [VC_W-1:0]  tin;
        logic [EC_W-1:0]  saved;
    } t_frame;

    function automatic logic [VC_W-1:0] tmin(input logic [VC_W-1:0] a,
                                             input logic [VC_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== design/biconnected_edge_components.sv =====
// ----------------------------------------------------------------------------
// biconnected_edge_components
// Edge loader, adjacency builder and iterative Tarjan search over RAMs.
// ----------------------------------------------------------------------------
// A load request without last_edge stores one edge, or sets overflow once
// the edge store is full, and gives no result. A read request reads the
// color RAM when accepted and registers its result once more before it is
// shown; reads can be issued back to back. A load with last_edge raises
// busy and runs the whole computation on one small sequencer with RAMs of
// one write and one read port: a clearing pass (entry times, seen flags,
// colors, offsets), a degree count over the edges, the prefix sum over the
// vertices, the adjacency fill, then the search: a scan for roots, entering
// a vertex, a step per adjacency entry, the return to the parent frame and
// the coloring of stacked edges. Results carry a strobe for one cycle; the
// receiver cannot stall, so every result must be taken as it comes.
module biconnected_edge_components
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  bec_pkg::t_req         i_req,
    output logic                  o_rsp_valid,
    output bec_pkg::t_rsp         o_rsp,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [10:0]           i_cfg_data
);
    import bec_pkg::*;
    `include "assert_macros.svh"

    localparam logic [4:0] S_IDLE = 5'd0,  S_SWEEP = 5'd1,  S_C0 = 5'd2,
                           S_C1 = 5'd3,    S_C2 = 5'd4,     S_C3 = 5'd5,
                           S_C4 = 5'd6,    S_P0 = 5'd7,     S_P1 = 5'd8,
                           S_F0 = 5'd9,    S_F1 = 5'd10,    S_F2 = 5'd11,
                           S_F3 = 5'd12,   S_F4 = 5'd13,    S_R0 = 5'd14,
                           S_R1 = 5'd15,   S_ENT0 = 5'd16,  S_ENT1 = 5'd17,
                           S_ENT2 = 5'd18, S_ADJ0 = 5'd19,  S_ADJ1 = 5'd20,
                           S_ADJ2 = 5'd21, S_POP0 = 5'd22,  S_POP1 = 5'd23,
                           S_COL0 = 5'd24, S_COL1 = 5'd25,  S_DONE = 5'd26;

    // ---------------- RAMs ----------------
    logic [2*V_W-1:0] ep_mem [MAX_EDGES];
    logic [OFF_W-1:0] off_mem [MAX_VERTICES+1];
    logic [OFF_W-1:0] fil_mem [MAX_VERTICES];
    logic [V_W+E_W-1:0] adj_mem [2*MAX_EDGES];
    logic [VC_W-1:0]  et_mem [MAX_VERTICES];
    logic             sn_mem [MAX_EDGES];
    logic [E_W-1:0]   stk_mem [MAX_EDGES];
    logic [E_W-1:0]   col_mem [MAX_EDGES];
    t_frame           frm_mem [MAX_VERTICES];

    logic ep_we, off_we, fil_we, adj_we, et_we, sn_we, stk_we, col_we, frm_we;
    logic [E_W-1:0]     ep_wa, ep_ra, sn_wa, sn_ra, stk_wa, stk_ra, col_wa, col_ra;
    logic [2*V_W-1:0]   ep_wd, ep_q;
    logic [V_W:0]       off_wa, off_ra;
    logic [OFF_W-1:0]   off_wd, off_q, fil_wd, fil_q;
    logic [V_W-1:0]     fil_wa, fil_ra, et_wa, et_ra, frm_wa, frm_ra;
    logic [A_W-1:0]     adj_wa, adj_ra;
    logic [V_W+E_W-1:0] adj_wd, adj_q;
    logic [VC_W-1:0]    et_wd, et_q;
    logic               sn_wd, sn_q;
    logic [E_W-1:0]     stk_wd, stk_q, col_wd, col_q;
    t_frame             frm_wd, frm_q;

    always_ff @(posedge i_clk) begin
        if (ep_we) ep_mem[ep_wa] <= ep_wd;
        ep_q <= ep_mem[ep_ra];
    end
    always_ff @(posedge i_clk) begin
        if (off_we) off_mem[off_wa] <= off_wd;
        off_q <= off_mem[off_ra];
    end
    always_ff @(posedge i_clk) begin
        if (fil_we) fil_mem[fil_wa] <= fil_wd;
        fil_q <= fil_mem[fil_ra];
    end
    always_ff @(posedge i_clk) begin
        if (adj_we) adj_mem[adj_wa] <= adj_wd;
        adj_q <= adj_mem[adj_ra];
    end
    always_ff @(posedge i_clk) begin
        if (et_we) et_mem[et_wa] <= et_wd;
        et_q <= et_mem[et_ra];
    end
    always_ff @(posedge i_clk) begin
        if (sn_we) sn_mem[sn_wa] <= sn_wd;
        sn_q <= sn_mem[sn_ra];
    end
    always_ff @(posedge i_clk) begin
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
        stk_q <= stk_mem[stk_ra];
    end
    always_ff @(posedge i_clk) begin
        if (col_we) col_mem[col_wa] <= col_wd;
        col_q <= col_mem[col_ra];
    end
    always_ff @(posedge i_clk) begin
        if (frm_we) frm_mem[frm_wa] <= frm_wd;
        frm_q <= frm_mem[frm_ra];
    end

    // ---------------- registers ----------------
    logic [4:0]       r_state, n_state;
    logic [VC_W-1:0]  r_vc, n_vc, r_n, n_n;
    logic [EC_W-1:0]  r_total, n_total, r_idx, n_idx, r_len, n_len, r_lim, n_lim;
    logic [12:0]      r_cc, n_cc;
    logic             r_fresh, n_fresh, r_ovf, n_ovf;
    logic [OFF_W-1:0] r_run, n_run;
    logic [V_W-1:0]   r_a, n_a, r_b, n_b, r_ev, n_ev, r_epar, n_epar, r_to, n_to;
    logic             r_epval, n_epval;
    logic [E_W-1:0]   r_e, n_e;
    logic [VC_W-1:0]  r_time, n_time, r_ret, n_ret;
    logic [VC_W-1:0]  r_depth, n_depth;
    t_frame           r_f, n_f;
    logic             r_col_root, n_col_root, r_col_any, n_col_any;
    logic             r_rd_pend, n_rd_pend, r_rd_in, n_rd_in;
    logic             r_rsp_valid, n_rsp_valid;
    t_rsp             r_rsp, n_rsp;

    logic             acc;
    logic [EC_W-1:0]  eff_total;
    logic [V_W-1:0]   q_a, q_b, q_to;
    logic [E_W-1:0]   q_e;
    logic             in_rng;
    logic [VC_W-1:0]  low_new;

    assign busy        = (r_state != S_IDLE);
    assign acc         = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    assign q_a     = ep_q[2*V_W-1:V_W];
    assign q_b     = ep_q[V_W-1:0];
    assign in_rng  = ({1'b0, q_a} < r_n) && ({1'b0, q_b} < r_n);
    assign q_to    = adj_q[V_W+E_W-1:E_W];
    assign q_e     = adj_q[E_W-1:0];
    assign low_new = tmin(r_f.low, et_q);
    assign eff_total = r_fresh ? '0 : r_total;

    always_comb begin
        // hold everything by default
        n_state = r_state;   n_vc = r_vc;       n_n = r_n;
        n_total = r_total;   n_idx = r_idx;     n_len = r_len;
        n_lim = r_lim;       n_cc = r_cc;       n_fresh = r_fresh;
        n_ovf = r_ovf;       n_run = r_run;     n_a = r_a;
        n_b = r_b;           n_ev = r_ev;       n_epar = r_epar;
        n_to = r_to;         n_epval = r_epval; n_e = r_e;
        n_time = r_time;     n_ret = r_ret;     n_depth = r_depth;
        n_f = r_f;           n_col_root = r_col_root;
        n_col_any = r_col_any;
        n_rd_pend = 1'b0;    n_rd_in = r_rd_in;
        n_rsp_valid = 1'b0;  n_rsp = r_rsp;

        ep_we = 1'b0;  ep_wa = eff_total[E_W-1:0];
        ep_wd = {i_req.from_vertex, i_req.to_vertex};
        ep_ra = r_idx[E_W-1:0];
        off_we = 1'b0; off_wa = r_idx[V_W:0]; off_wd = '0; off_ra = r_idx[V_W:0];
        fil_we = 1'b0; fil_wa = r_idx[V_W-1:0]; fil_wd = r_run; fil_ra = r_a;
        adj_we = 1'b0; adj_wa = fil_q[A_W-1:0]; adj_wd = {r_b, r_idx[E_W-1:0]};
        adj_ra = r_f.pos[A_W-1:0];
        et_we = 1'b0;  et_wa = r_idx[V_W-1:0]; et_wd = TIME_INF;
        et_ra = r_idx[V_W-1:0];
        sn_we = 1'b0;  sn_wa = r_idx[E_W-1:0]; sn_wd = 1'b0; sn_ra = q_e;
        stk_we = 1'b0; stk_wa = r_len[E_W-1:0]; stk_wd = r_e;
        stk_ra = E_W'(r_len - 1'b1);
        col_we = 1'b0; col_wa = r_idx[E_W-1:0]; col_wd = '0;
        col_ra = i_req.edge_index;
        frm_we = 1'b0; frm_wa = V_W'(r_depth - 1'b1); frm_wd = r_f;
        frm_ra = V_W'(r_depth - VC_W'(2));

        if (i_cfg_valid) n_vc = i_cfg_data;

        // read answers: RAM read in the accept cycle, formatted in the cycle after
        if (r_rd_pend) begin
            n_rsp_valid           = 1'b1;
            n_rsp.is_count        = 1'b0;
            n_rsp.component_count = r_cc;
            n_rsp.edge_color      = r_rd_in ? (13'(col_q) + 13'd1) : 13'd0;
            n_rsp.overflow        = r_ovf;
        end

        case (r_state)
            S_IDLE: begin
                if (acc && i_req.operation == OP_READ) begin
                    n_rd_pend = 1'b1;
                    n_rd_in   = ({1'b0, i_req.edge_index} < r_total);
                end else if (acc) begin
                    n_fresh = 1'b0;
                    n_ovf   = r_fresh ? 1'b0 : r_ovf;
                    n_total = eff_total;
                    if (eff_total < EC_W'(MAX_EDGES)) begin
                        ep_we   = 1'b1;
                        n_total = eff_total + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_req.last_edge) begin
                        n_state = S_SWEEP;
                        n_idx   = '0;
                        n_n     = (r_vc > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : r_vc;
                    end
                end
            end
            S_SWEEP: begin
                // clear entry times, seen flags, colors and offsets
                et_we  = (r_idx < EC_W'(MAX_VERTICES));
                off_we = (r_idx <= EC_W'(MAX_VERTICES));
                sn_we  = 1'b1;
                col_we = 1'b1;
                if (r_idx == EC_W'(MAX_EDGES - 1)) begin
                    n_idx   = '0;
                    n_state = S_C0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // degree count
            S_C0: begin
                if (r_idx == r_total) begin
                    n_idx = '0; n_run = '0; n_state = S_P0;
                end else begin
                    n_state = S_C1;
                end
            end
            S_C1: begin
                off_ra = (V_W+1)'(q_a) + 1'b1;
                n_a = q_a; n_b = q_b;
                if (in_rng) begin
                    n_state = S_C2;
                end else begin
                    n_idx = r_idx + 1'b1; n_state = S_C0;
                end
            end
            S_C2: begin
                off_we = 1'b1; off_wa = (V_W+1)'(r_a) + 1'b1; off_wd = off_q + 1'b1;
                n_state = S_C3;
            end
            S_C3: begin
                off_ra = (V_W+1)'(r_b) + 1'b1;
                n_state = S_C4;
            end
            S_C4: begin
                off_we = 1'b1; off_wa = (V_W+1)'(r_b) + 1'b1; off_wd = off_q + 1'b1;
                n_idx = r_idx + 1'b1; n_state = S_C0;
            end
            // exclusive prefix sum, also seeds the fill pointers
            S_P0: begin
                off_ra = r_idx[V_W:0] + 1'b1;
                if (r_idx == EC_W'(r_n)) begin
                    n_idx = '0; n_state = S_F0;
                end else begin
                    n_state = S_P1;
                end
            end
            S_P1: begin
                off_we = 1'b1; off_wa = r_idx[V_W:0] + 1'b1; off_wd = r_run + off_q;
                fil_we = 1'b1;
                n_run = r_run + off_q;
                n_idx = r_idx + 1'b1; n_state = S_P0;
            end
            // adjacency fill
            S_F0: begin
                if (r_idx == r_total) begin
                    n_idx = '0; n_time = '0; n_cc = '0; n_len = '0; n_depth = '0;
                    n_state = S_R0;
                end else begin
                    n_state = S_F1;
                end
            end
            S_F1: begin
                fil_ra = q_a;
                n_a = q_a; n_b = q_b;
                if (in_rng) begin
                    n_state = S_F2;
                end else begin
                    n_idx = r_idx + 1'b1; n_state = S_F0;
                end
            end
            S_F2: begin
                adj_we = 1'b1;
                fil_we = 1'b1; fil_wa = r_a; fil_wd = fil_q + 1'b1;
                n_state = S_F3;
            end
            S_F3: begin
                fil_ra = r_b;
                n_state = S_F4;
            end
            S_F4: begin
                adj_we = 1'b1; adj_wd = {r_a, r_idx[E_W-1:0]};
                fil_we = 1'b1; fil_wa = r_b; fil_wd = fil_q + 1'b1;
                n_idx = r_idx + 1'b1; n_state = S_F0;
            end
            // root scan
            S_R0: begin
                n_state = (r_idx == EC_W'(r_n)) ? S_DONE : S_R1;
            end
            S_R1: begin
                if (et_q == TIME_INF) begin
                    n_ev = r_idx[V_W-1:0]; n_epval = 1'b0; n_epar = '0;
                    n_state = S_ENT0;
                end else begin
                    n_idx = r_idx + 1'b1; n_state = S_R0;
                end
            end
            // enter a vertex: stamp time, fetch its adjacency range
            S_ENT0: begin
                n_time = r_time + 1'b1;
                et_we = 1'b1; et_wa = r_ev; et_wd = r_time + 1'b1;
                off_ra = {1'b0, r_ev};
                n_state = S_ENT1;
            end
            S_ENT1: begin
                off_ra  = (V_W+1)'(r_ev) + 1'b1;
                n_f.pos = off_q;
                n_state = S_ENT2;
            end
            S_ENT2: begin
                n_f.lim = off_q;   n_f.v = r_ev;
                n_f.par = r_epar;  n_f.par_vld = r_epval;
                n_f.low = r_time;  n_f.tin = r_time; n_f.saved = '0;
                n_depth = r_depth + 1'b1;
                n_state = S_ADJ0;
            end
            S_ADJ0: begin
                if (r_f.pos < r_f.lim) begin
                    n_f.pos = r_f.pos + 1'b1; n_state = S_ADJ1;
                end else begin
                    n_state = S_POP0;
                end
            end
            S_ADJ1: begin
                et_ra = q_to;
                n_to = q_to; n_e = q_e;
                // skip every edge back to the parent vertex
                n_state = (r_f.par_vld && q_to == r_f.par) ? S_ADJ0 : S_ADJ2;
            end
            S_ADJ2: begin
                n_f.low = low_new;
                if (!sn_q && r_len < EC_W'(MAX_EDGES)) begin
                    stk_we = 1'b1;
                    sn_we = 1'b1; sn_wa = r_e; sn_wd = 1'b1;
                    n_len = r_len + 1'b1;
                end
                n_state = S_ADJ0;
                if (et_q == TIME_INF && r_depth < VC_W'(MAX_VERTICES)) begin
                    frm_we = 1'b1;
                    frm_wd.low = low_new; frm_wd.saved = r_len;
                    n_ev = r_to; n_epar = r_f.v; n_epval = 1'b1;
                    n_state = S_ENT0;
                end
            end
            S_POP0: begin
                n_ret = r_f.low;
                if (r_depth > VC_W'(1)) begin
                    n_depth = r_depth - 1'b1; n_state = S_POP1;
                end else begin
                    n_depth = '0; n_lim = '0; n_col_root = 1'b1; n_col_any = 1'b0;
                    n_state = S_COL0;
                end
            end
            S_POP1: begin
                n_f = frm_q;
                n_f.low = tmin(frm_q.low, r_ret);
                if (r_ret >= frm_q.tin) begin
                    n_lim = frm_q.saved; n_col_root = 1'b0; n_state = S_COL0;
                end else begin
                    n_state = S_ADJ0;
                end
            end
            // drain the edge stack down to the limit with the current color
            S_COL0: begin
                if (r_len > r_lim) begin
                    n_len = r_len - 1'b1; n_col_any = 1'b1; n_state = S_COL1;
                end else begin
                    if (!r_col_root || r_col_any) n_cc = r_cc + 1'b1;
                    if (r_col_root) begin
                        n_idx = r_idx + 1'b1; n_state = S_R0;
                    end else begin
                        n_state = S_ADJ0;
                    end
                end
            end
            S_COL1: begin
                col_we = 1'b1; col_wa = stk_q; col_wd = r_cc[E_W-1:0];
                n_state = S_COL0;
            end
            S_DONE: begin
                n_rsp_valid           = 1'b1;
                n_rsp.is_count        = 1'b1;
                n_rsp.component_count = r_cc;
                n_rsp.edge_color      = '0;
                n_rsp.overflow        = r_ovf;
                n_fresh = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vc        <= VC_W'(1);
            r_total     <= '0;
            r_fresh     <= 1'b1;
            r_ovf       <= 1'b0;
            r_cc        <= '0;
            r_len       <= '0;
            r_depth     <= '0;
            r_time      <= '0;
            r_rd_pend   <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vc        <= n_vc;
            r_total     <= n_total;
            r_fresh     <= n_fresh;
            r_ovf       <= n_ovf;
            r_cc        <= n_cc;
            r_len       <= n_len;
            r_depth     <= n_depth;
            r_time      <= n_time;
            r_rd_pend   <= n_rd_pend;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;       r_idx <= n_idx;   r_lim <= n_lim;   r_run <= n_run;
        r_a <= n_a;       r_b <= n_b;       r_ev <= n_ev;     r_epar <= n_epar;
        r_to <= n_to;     r_epval <= n_epval; r_e <= n_e;     r_ret <= n_ret;
        r_f <= n_f;       r_col_root <= n_col_root; r_col_any <= n_col_any;
        r_rd_in <= n_rd_in; r_rsp <= n_rsp;
    end

    // ---------------- assertions ----------------
    `ASSERT_CLK(a_count_after_run, (o_rsp_valid && o_rsp.is_count) |-> $past(busy), "count result without a run")
    `ASSERT_NEVER(a_stack_bound, r_len > EC_W'(MAX_EDGES), "edge stack overrun")
    `ASSERT_NEVER(a_depth_bound, r_depth > VC_W'(MAX_VERTICES), "frame stack overrun")
    `ASSERT_CLK(a_idle_empty, (r_state == S_IDLE) |-> (r_depth == '0 && r_len == '0), "stacks not empty at idle")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biconnected edge component testbench
// Loads edge lists, lets the block color them by biconnected component and
// reads the colors back. Each response is checked against an in-bench Tarjan
// predictor or a typed row's value, directed rows first, random graphs after.
// ----------------------------------------------------------------------------
module tb;
    import bec_pkg::*;

    localparam int unsigned NO_PARENT = 32'hFFFF_FFFF;
    localparam int unsigned T_INF     = MAX_VERTICES + 1;
    localparam int          ITEM_GOAL = 1550;
    localparam int          QUIET_AT  = 1400;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       o_rsp_valid;
    t_rsp       o_rsp;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [10:0] i_cfg_data;

    biconnected_edge_components dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the graph, colors and flags
    // ------------------------------------------------------------------------
    int unsigned vcount;
    logic [V_W-1:0] end_a [MAX_EDGES];
    logic [V_W-1:0] end_b [MAX_EDGES];
    int unsigned    edges_held;
    int unsigned    edge_comp [MAX_EDGES];
    int unsigned    comp_total;
    bit             new_graph;
    bit             dropped;

    t_rsp pending_rsp [$];
    bit   failed;
    int   items;
    bit   quiet;

    // Color every held edge by its biconnected component (iterative DFS).
    function automatic void color_components();
        int unsigned n, sl, t, d, top, to, e, sv, ret, p, a, b;
        int unsigned off [MAX_VERTICES+1];
        int unsigned fill [MAX_VERTICES];
        int unsigned adj_to [2*MAX_EDGES];
        int unsigned adj_e [2*MAX_EDGES];
        int unsigned tin [MAX_VERTICES];
        int unsigned stk [MAX_EDGES];
        bit          seen [MAX_EDGES];
        int unsigned fv [MAX_VERTICES];
        int unsigned fp [MAX_VERTICES];
        int unsigned fpos [MAX_VERTICES];
        int unsigned flow [MAX_VERTICES];
        int unsigned fsav [MAX_VERTICES];
        n = (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
        for (int i = 0; i <= MAX_VERTICES; i++) off[i] = 0;
        for (int i = 0; i < edges_held; i++) begin
            a = end_a[i];
            b = end_b[i];
            if (a < n && b < n) begin
                off[a+1]++;
                off[b+1]++;
            end
        end
        for (int i = 0; i < n; i++) begin
            off[i+1] += off[i];
            fill[i] = off[i];
        end
        for (int i = 0; i < edges_held; i++) begin
            a = end_a[i];
            b = end_b[i];
            if (a < n && b < n) begin
                adj_to[fill[a]] = b; adj_e[fill[a]] = i; fill[a]++;
                adj_to[fill[b]] = a; adj_e[fill[b]] = i; fill[b]++;
            end
        end
        for (int i = 0; i < MAX_VERTICES; i++) tin[i] = T_INF;
        for (int i = 0; i < MAX_EDGES; i++) seen[i] = 1'b0;
        for (int i = 0; i < edges_held; i++) edge_comp[i] = 0;
        t = 0;
        comp_total = 0;
        sl = 0;
        for (int r = 0; r < n; r++) begin
            if (tin[r] == T_INF) begin
                t++;
                tin[r] = t;
                fv[0] = r; fp[0] = NO_PARENT; fpos[0] = off[r]; flow[0] = t; fsav[0] = 0;
                d = 1;
                while (d > 0) begin
                    top = d - 1;
                    if (fpos[top] < off[fv[top]+1]) begin
                        to = adj_to[fpos[top]];
                        e  = adj_e[fpos[top]];
                        fpos[top]++;
                        // parallel edges to the parent are skipped by vertex
                        if (to != fp[top]) begin
                            sv = sl;
                            if (tin[to] < flow[top]) flow[top] = tin[to];
                            if (!seen[e] && sl < MAX_EDGES) begin
                                stk[sl] = e;
                                sl++;
                                seen[e] = 1'b1;
                            end
                            if (tin[to] == T_INF && d < MAX_VERTICES) begin
                                fsav[top] = sv;
                                t++;
                                tin[to] = t;
                                fv[d] = to; fp[d] = fv[top]; fpos[d] = off[to];
                                flow[d] = t; fsav[d] = 0;
                                d++;
                            end
                        end
                    end else begin
                        ret = flow[top];
                        d--;
                        if (d > 0) begin
                            p = d - 1;
                            if (ret < flow[p]) flow[p] = ret;
                            if (ret >= tin[fv[p]]) begin
                                while (sl > fsav[p]) begin
                                    sl--;
                                    edge_comp[stk[sl]] = comp_total;
                                end
                                comp_total++;
                            end
                        end
                    end
                end
                // leftovers of this root form one more component
                if (sl > 0) begin
                    while (sl > 0) begin
                        sl--;
                        edge_comp[stk[sl]] = comp_total;
                    end
                    comp_total++;
                end
            end
        end
    endfunction

    // Advance the predictor by one accepted request; return 1 if it answers.
    function automatic bit predict_response(input t_req r, output t_rsp rsp);
        rsp = '0;
        if (r.operation == OP_LOAD) begin
            if (new_graph) begin
                edges_held = 0;
                dropped    = 1'b0;
                new_graph  = 1'b0;
            end
            if (edges_held < MAX_EDGES) begin
                end_a[edges_held] = r.from_vertex;
                end_b[edges_held] = r.to_vertex;
                edges_held++;
            end else begin
                dropped = 1'b1;
            end
            if (!r.last_edge) return 1'b0;
            color_components();
            new_graph = 1'b1;
            rsp.is_count        = 1'b1;
            rsp.component_count = 13'(comp_total);
            rsp.overflow        = dropped;
            return 1'b1;
        end
        rsp.is_count        = 1'b0;
        rsp.component_count = 13'(comp_total);
        rsp.edge_color      = (r.edge_index < edges_held) ?
                              13'(edge_comp[r.edge_index] + 1) : 13'd0;
        rsp.overflow        = dropped;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers: called at a rising edge, return at the accepting edge
    // ------------------------------------------------------------------------
    task automatic issue_request(input t_req r, input bit typed, input t_rsp typed_rsp);
        t_rsp rsp;
        bit   has;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        items++;
        has = predict_response(r, rsp);
        if (has) pending_rsp = {pending_rsp, (typed ? typed_rsp : rsp)};
    endtask

    task automatic send(input t_req r);
        issue_request(r, 1'b0, '0);
    endtask

    // Drop start for a random burst now and then, never in the quiet tail.
    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Write vertex_count once the block has drained every response.
    task automatic write_vcount(input logic [10:0] value);
        start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        vcount = value;
    endtask

    function automatic t_req rand_req();
        t_req       r;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        r = raw[$bits(t_req)-1:0];
        return r;
    endfunction

    function automatic t_req load_req(input int unsigned a, input int unsigned b,
                                      input bit last);
        t_req r;
        r = rand_req();
        r.operation   = OP_LOAD;
        r.from_vertex = a[V_W-1:0];
        r.to_vertex   = b[V_W-1:0];
        r.last_edge   = last;
        return r;
    endfunction

    function automatic t_req read_req(input int unsigned k);
        t_req r;
        r = rand_req();
        r.operation  = OP_READ;
        r.edge_index = k[E_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    typedef struct {
        bit          is_cfg;
        logic [10:0] cfg;
        t_req        req;
        bit          typed;
        t_rsp        rsp;
    } t_row;

    t_row rows [$];

    function automatic t_row row_req(input t_req r);
        t_row w;
        w = '{default: '0};
        w.req = r;
        return w;
    endfunction

    function automatic t_row row_typed(input t_req r, input bit cnt,
                                       input int unsigned comps, input int unsigned color);
        t_row w;
        w = row_req(r);
        w.typed = 1'b1;
        w.rsp   = '{is_count: cnt, component_count: 13'(comps),
                    edge_color: 13'(color), overflow: 1'b0};
        return w;
    endfunction

    function automatic t_row row_cfg(input logic [10:0] v);
        t_row w;
        w = '{default: '0};
        w.is_cfg = 1'b1;
        w.cfg    = v;
        return w;
    endfunction

    function automatic void add_row(input t_row w);
        rows = {rows, w};
    endfunction

    function automatic void build_rows();
        // after reset nothing is held: every read gives zero
        add_row(row_typed(read_req(0), 0, 0, 0));
        add_row(row_typed(read_req(4095), 0, 0, 0));
        // self loop on the only vertex is one component
        add_row(row_typed(load_req(0, 0, 1), 1, 1, 0));
        add_row(row_typed(read_req(0), 0, 1, 1));
        add_row(row_typed(read_req(4095), 0, 1, 0));
        // endpoint out of range: unreached, color reads as one
        add_row(row_typed(load_req(1023, 1023, 1), 1, 0, 0));
        add_row(row_typed(read_req(0), 0, 0, 1));
        // count above the vertex limit saturates
        add_row(row_cfg(11'd2047));
        add_row(row_req(load_req(0, 1, 0)));
        add_row(row_req(load_req(1, 2, 0)));
        add_row(row_req(load_req(2, 0, 0)));
        add_row(row_req(load_req(2, 3, 0)));
        add_row(row_req(load_req(3, 4, 0)));
        add_row(row_req(load_req(4, 3, 0)));
        add_row(row_req(load_req(1023, 512, 1)));
        for (int k = 0; k < 7; k++) add_row(row_req(read_req(k)));
        // no vertices at all: nothing is colored
        add_row(row_cfg(11'd0));
        add_row(row_typed(load_req(5, 6, 1), 1, 0, 0));
        add_row(row_typed(read_req(0), 0, 0, 1));
        add_row(row_cfg(11'd1024));
    endfunction

    // ------------------------------------------------------------------------
    // Random graphs
    // ------------------------------------------------------------------------
    task automatic random_graph();
        int unsigned mode, nv, ne, a, b, span, reads;
        mode = $urandom_range(0, 9);
        if (mode < 7) nv = $urandom_range(1, 12);
        else if (mode < 9) nv = 1024;
        else nv = $urandom_range(0, 2047);
        if (nv != vcount || $urandom_range(0, 7) == 0) write_vcount(11'(nv));
        span = (nv == 0) ? 4 : ((nv > MAX_VERTICES) ? MAX_VERTICES : nv);
        ne   = (nv >= 1024) ? $urandom_range(1, 40) : $urandom_range(1, 24);
        for (int i = 0; i < ne; i++) begin
            a = $urandom_range(0, span - 1);
            b = $urandom_range(0, span - 1);
            // a little noise: an endpoint anywhere in 0..1023, possibly past the vertex count
            if ($urandom_range(0, 15) == 0) a = $urandom_range(0, 1023);
            maybe_idle();
            send(load_req(a, b, i == ne - 1));
            // a read past the partial list is harmless mid-load
            if (i < ne - 1 && $urandom_range(0, 19) == 0) begin
                maybe_idle();
                send(read_req($urandom_range(edges_held, 4095)));
            end
        end
        reads = $urandom_range(3, 12);
        for (int i = 0; i < reads; i++) begin
            maybe_idle();
            if ($urandom_range(0, 4) == 0) send(read_req($urandom_range(0, 4095)));
            else send(read_req($urandom_range(0, edges_held)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Response checker: the block cannot be stalled, take each as it comes
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid) begin
            if (pending_rsp.size() == 0) begin
                failed <= 1'b1;
                $display("%0t: unexpected response %p", $time, o_rsp);
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.is_count !== want.is_count ||
                    o_rsp.component_count !== want.component_count ||
                    o_rsp.edge_color !== want.edge_color ||
                    o_rsp.overflow !== want.overflow) begin
                    failed <= 1'b1;
                    $display("%0t: expected %p, got %p", $time, want, o_rsp);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        failed      = 1'b0;
        items       = 0;
        quiet       = 1'b0;
        vcount      = 1;
        edges_held  = 0;
        comp_total  = 0;
        new_graph   = 1'b1;
        dropped     = 1'b0;
        build_rows();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_vcount(rows[i].cfg);
            else issue_request(rows[i].req, rows[i].typed, rows[i].rsp);
        end

        while (items < ITEM_GOAL) begin
            quiet = (items >= QUIET_AT);
            random_graph();
        end
        start <= 1'b0;

        // drain, then allow the read pipeline to settle
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (!failed && pending_rsp.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hang guard, far above the slowest correct run (clearing passes included).
    initial begin
        #(12 * 5_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/bec_pkg.sv
design/biconnected_edge_components.sv
tb/sv/tb.sv
